// ----- src/b64enc_pkg.sv -----
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the character lookup for the Base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_SLASH = 7'h2F;
    localparam logic [6:0] CHAR_UPPER = 7'h41;
    localparam logic [6:0] LOWER_OFS  = 7'd71;
    localparam logic [6:0] DIGIT_OFS  = 7'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       run_last;
        logic       message_end;
    } out_t;

    // one group of up to three bytes; have counts valid bytes (1..3)
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] have;
        logic       fin;
    } group_t;

    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        c = 7'(v);
        if (v < 6'd26)
            return CHAR_UPPER + c;
        else if (v < 6'd52)
            return c + LOWER_OFS;
        else if (v < 6'd62)
            return c - DIGIT_OFS;
        else if (v == 6'd62)
            return CHAR_PLUS;
        else
            return CHAR_SLASH;
    endfunction

endpackage

// ----- src/base64_stream_encoder_core.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming Base64 encoder with queue-style byte input and character output.
// ----------------------------------------------------------------------------
// One byte enters per cycle while full is low; every group of three bytes,
// or the partial group closed by a byte marked final, turns into four
// characters that leave one per cycle while pop is high. Groups wait in a
// short queue (QUEUE_DEPTH entries) between the byte collector and the
// character emitter; full rises only when that queue is full. The byte
// closing a group is written into that queue, and its first character is
// then registered in the result register of the emitter.
module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  b64enc_pkg::in_t  item,
    output logic             empty,
    input  logic             pop,
    output b64enc_pkg::out_t result
);
    import b64enc_pkg::*;

    logic   grp_wr, grp_rd, grp_full, grp_empty;
    group_t grp_wr_data, grp_rd_data;

    b64enc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .grp_full (grp_full),
        .full     (full),
        .grp_wr   (grp_wr),
        .grp_data (grp_wr_data)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (grp_wr),
        .wr_data (grp_wr_data),
        .rd      (grp_rd),
        .full    (grp_full),
        .empty   (grp_empty),
        .rd_data (grp_rd_data)
    );

    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_empty (grp_empty),
        .grp_data  (grp_rd_data),
        .grp_rd    (grp_rd),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

// ----- src/b64enc_front.sv -----
// ----------------------------------------------------------------------------
// b64enc_front
// Collects incoming bytes into groups of three and hands complete or
// flushed groups to the group queue.
// ----------------------------------------------------------------------------
module b64enc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64enc_pkg::in_t   item,
    input  logic              grp_full,
    output logic              full,
    output logic              grp_wr,
    output b64enc_pkg::group_t grp_data
);
    import b64enc_pkg::*;

    logic [7:0] pend0_reg, pend0_next;
    logic [7:0] pend1_reg, pend1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;
    logic       flush;

    assign full   = grp_full;
    assign accept = push && !grp_full;
    assign flush  = (cnt_reg == 2'd2) || item.final_byte;
    assign grp_wr = accept && flush;

    always_comb
    begin
        grp_data.b0   = (cnt_reg == 2'd0) ? item.data_byte : pend0_reg;
        grp_data.b1   = (cnt_reg == 2'd1) ? item.data_byte :
                        (cnt_reg == 2'd2) ? pend1_reg : 8'd0;
        grp_data.b2   = (cnt_reg == 2'd2) ? item.data_byte : 8'd0;
        grp_data.have = cnt_reg + 2'd1;
        grp_data.fin  = item.final_byte;
    end

    always_comb
    begin
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            if (flush)
            begin
                // drop the pending bytes, start a fresh group
                pend0_next = 8'd0;
                pend1_next = 8'd0;
                cnt_next   = 2'd0;
            end
            else
            begin
                if (cnt_reg == 2'd0)
                    pend0_next = item.data_byte;
                else
                    pend1_next = item.data_byte;
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend0_reg <= 8'd0;
            pend1_reg <= 8'd0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("pending count out of range");

endmodule

// ----- src/b64enc_queue.sv -----
// ----------------------------------------------------------------------------
// b64enc_queue
// Short queue of byte groups between the front and the back.
// ----------------------------------------------------------------------------
module b64enc_queue #(
    parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  b64enc_pkg::group_t wr_data,
    input  logic               rd,
    output logic               full,
    output logic               empty,
    output b64enc_pkg::group_t rd_data
);
    import b64enc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("group queue overflow");

endmodule

// ----- src/b64enc_back.sv -----
// ----------------------------------------------------------------------------
// b64enc_back
// Splits each queued group into four sextets and emits one character per
// transfer through the result register.
// ----------------------------------------------------------------------------
module b64enc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               grp_empty,
    input  b64enc_pkg::group_t grp_data,
    output logic               grp_rd,
    input  logic               pop,
    output logic               empty,
    output b64enc_pkg::out_t   result
);
    import b64enc_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    out_t       result_reg, result_next;
    logic       load;
    logic [5:0] sext;

    assign empty  = !valid_reg;
    assign result = result_reg;
    assign load   = !grp_empty && (!valid_reg || pop);
    assign grp_rd = load && (idx_reg == 2'd3);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sext = grp_data.b0[7:2];
            2'd1:    sext = {grp_data.b0[1:0], grp_data.b1[7:4]};
            2'd2:    sext = {grp_data.b1[3:0], grp_data.b2[7:6]};
            2'd3:    sext = grp_data.b2[5:0];
            default: sext = 6'd0;
        endcase
    end

    always_comb
    begin
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        result_next = result_reg;
        if (load)
        begin
            result_next.out_char    = (idx_reg <= grp_data.have) ? b64_char(sext) : PAD_CHAR;
            result_next.run_last    = (idx_reg == 2'd3);
            result_next.message_end = (idx_reg == 2'd3) && grp_data.fin;
            idx_next                = idx_reg + 2'd1;
            valid_next              = 1'b1;
        end
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.message_end) |-> result_reg.run_last)
        else $error("message end without run last");

    a_group_held: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> !grp_empty)
        else $error("group left the queue mid-emission");

    a_last_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (load && result_next.run_last) |=> (idx_reg == 2'd0))
        else $error("character index out of step");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for base64_stream_encoder_core: a directed table of known
// encodings followed by random messages and noise bytes. Every character
// transfer is checked field by field against the table text for typed rows,
// else an in-bench encoder, with random gaps on byte and character sides.
// ----------------------------------------------------------------------------
module tb;

    import b64enc_pkg::*;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int N_DIRECTED   = 25;
    localparam int RANDOM_ITEMS = 225;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        final_byte;
        logic        typed;
        logic [31:0] text;
    } row_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    in_t  item;
    logic empty;
    logic pop;
    out_t result;

    logic        typed_row;
    logic [31:0] typed_text;

    logic [7:0] held_bytes [2];
    logic [1:0] held_count;
    out_t       expected_chars [$];
    int         err_count;
    bit         calm;
    int         random_sent;

    row_t encode_table [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, "AA=="},
        '{8'hFF, 1'b1, 1'b1, "/w=="},
        '{8'h00, 1'b0, 1'b0, "    "},
        '{8'h00, 1'b1, 1'b1, "AAA="},
        '{8'hFF, 1'b0, 1'b0, "    "},
        '{8'hFF, 1'b1, 1'b1, "//8="},
        '{8'h00, 1'b0, 1'b0, "    "},
        '{8'h00, 1'b0, 1'b0, "    "},
        '{8'h00, 1'b1, 1'b1, "AAAA"},
        '{8'hFF, 1'b0, 1'b0, "    "},
        '{8'hFF, 1'b0, 1'b0, "    "},
        '{8'hFF, 1'b1, 1'b1, "////"},
        '{8'h4D, 1'b0, 1'b0, "    "},
        '{8'h61, 1'b0, 1'b0, "    "},
        '{8'h6E, 1'b0, 1'b1, "TWFu"},
        '{8'h4D, 1'b1, 1'b1, "TQ=="},
        '{8'h4D, 1'b0, 1'b0, "    "},
        '{8'h61, 1'b1, 1'b1, "TWE="},
        '{8'hFB, 1'b0, 1'b0, "    "},
        '{8'hEF, 1'b0, 1'b0, "    "},
        '{8'hBE, 1'b1, 1'b1, "++++"},
        '{8'h12, 1'b0, 1'b0, "    "},
        '{8'h34, 1'b0, 1'b0, "    "},
        '{8'h56, 1'b0, 1'b0, "    "},
        '{8'h78, 1'b1, 1'b0, "    "}
    };

    base64_stream_encoder_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int encode_byte(input in_t it, output out_t [3:0] chars);
        logic [7:0]      g0;
        logic [7:0]      g1;
        logic [7:0]      g2;
        logic [1:0]      cnt;
        logic [3:0][5:0] sx;
        int              have;
        int              idx;
        chars = '0;
        cnt = (held_count > 2'd2) ? 2'd2 : held_count;
        g0 = held_bytes[0];
        g1 = held_bytes[1];
        g2 = 8'h00;
        case (cnt)
            2'd0:    g0 = it.data_byte;
            2'd1:    g1 = it.data_byte;
            default: g2 = it.data_byte;
        endcase
        have = int'(cnt) + 1;
        if (have < 3 && !it.final_byte)
        begin
            held_bytes[cnt] = it.data_byte;
            held_count = 2'(have);
            return 0;
        end
        if (have < 2)
            g1 = 8'h00;
        if (have < 3)
            g2 = 8'h00;
        sx[0] = g0[7:2];
        sx[1] = {g0[1:0], g1[7:4]};
        sx[2] = {g1[3:0], g2[7:6]};
        sx[3] = g2[5:0];
        for (int k = 0; k < 4; k++)
        begin
            idx = int'(sx[k]);
            chars[k].out_char    = (k < have + 1) ? ALPHABET[8*(63-idx) +: 7] : PAD_CHAR;
            chars[k].run_last    = (k == 3);
            chars[k].message_end = (k == 3) && it.final_byte;
        end
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        held_count = 2'd0;
        return 4;
    endfunction

    always @(posedge clk)
    begin
        out_t         want;
        out_t [3:0]   chars;
        int           n;
        if (rst_n)
        begin
            if (!empty && pop)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected character transfer %h", $time, result);
                    err_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (result.out_char !== want.out_char)
                    begin
                        $display("%0t: out_char expected %h actual %h",
                                 $time, want.out_char, result.out_char);
                        err_count++;
                    end
                    if (result.run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %b actual %b",
                                 $time, want.run_last, result.run_last);
                        err_count++;
                    end
                    if (result.message_end !== want.message_end)
                    begin
                        $display("%0t: message_end expected %b actual %b",
                                 $time, want.message_end, result.message_end);
                        err_count++;
                    end
                end
            end
            if (push && !full)
            begin
                n = encode_byte(item, chars);
                for (int k = 0; k < n; k++)
                begin
                    if (typed_row)
                    begin
                        want.out_char    = typed_text[8*(3-k) +: 7];
                        want.run_last    = (k == 3);
                        want.message_end = (k == 3) && item.final_byte;
                        expected_chars.push_back(want);
                    end
                    else
                        expected_chars.push_back(chars[k]);
                end
            end
        end
    end

    initial
    begin
        int hold_cnt;
        hold_cnt = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cnt != 0)
            begin
                pop <= 1'b0;
                hold_cnt--;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic f, input logic t,
                             input logic [31:0] txt);
        int gap;
        item <= '{data_byte: d, final_byte: f};
        typed_row <= t;
        typed_text <= txt;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_chars();
        push <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    initial
    begin
        int len;
        err_count = 0;
        calm = 1'b0;
        random_sent = 0;
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        held_count = 2'd0;
        rst_n <= 1'b0;
        push <= 1'b0;
        item <= '0;
        typed_row <= 1'b0;
        typed_text <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(encode_table[i].data_byte, encode_table[i].final_byte,
                      encode_table[i].typed, encode_table[i].text);

        // hold the byte side until every character has come out
        drain_chars();

        while (random_sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                send_byte(pick_byte(), 1'($urandom_range(0, 1)), 1'b0, '0);
                random_sent++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
                for (int j = 0; j < len; j++)
                    send_byte(pick_byte(), j == len - 1, 1'b0, '0);
                random_sent += len;
            end
            if ($urandom_range(0, 19) == 0)
                drain_chars();
        end
        calm = 1'b0;

        drain_chars();
        repeat (16) @(posedge clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
src/b64enc_pkg.sv
src/b64enc_front.sv
src/b64enc_queue.sv
src/b64enc_back.sv
src/base64_stream_encoder_core.sv
tb/sv/tb.sv
